// File: src/twns_pkg.sv
// shared types, constants and arithmetic helpers for the nearest-texel sampler
// no dependencies; imported by every module of the block

package twns_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int COORD_BITS = 24;
   localparam int FX_BITS    = FRAC_BITS + 1;
   localparam int POS_BITS   = 8;
   localparam int SIZE_BITS  = 9;
   localparam int TEX_DEPTH  = 65536;
   localparam int ADDR_BITS  = $clog2(TEX_DEPTH);
   localparam int TEXEL_BITS = 32;
   localparam int IDX_BITS   = 16;
   localparam int MAX_SIZE   = 1 << POS_BITS;

   localparam logic [FX_BITS-1:0]    ONE_FX   = FX_BITS'(1) << FRAC_BITS;
   localparam logic [COORD_BITS-1:0] ONE_WIDE = COORD_BITS'(1) << FRAC_BITS;
   localparam logic [FRAC_BITS-1:0]  HALF_FX  = FRAC_BITS'(1) << (FRAC_BITS - 1);

   // wrap mode codes
   localparam logic [1:0] WRAP_REPEAT = 2'd0;
   localparam logic [1:0] WRAP_CLAMP  = 2'd1;
   localparam logic [1:0] WRAP_MIRROR = 2'd2;

   // action codes on the request side
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_WRITE  = 1'b1;

   // register indexes
   localparam logic [1:0] REG_TEX_WIDTH  = 2'd0;
   localparam logic [1:0] REG_TEX_HEIGHT = 2'd1;
   localparam logic [1:0] REG_WRAP_U     = 2'd2;
   localparam logic [1:0] REG_WRAP_V     = 2'd3;

   typedef struct packed {
      logic [POS_BITS-1:0]  lim_x;
      logic [POS_BITS-1:0]  lim_y;
      logic [SIZE_BITS-1:0] width;
      logic [1:0]           wrap_u;
      logic [1:0]           wrap_v;
   } cfg_type;

   typedef struct packed {
      logic                  is_write;
      logic [FX_BITS-1:0]    u;
      logic [FX_BITS-1:0]    vf;
      logic [IDX_BITS-1:0]   wr_index;
      logic [TEXEL_BITS-1:0] wr_texel;
   } coord_word_type;

   typedef struct packed {
      logic                  is_write;
      logic [POS_BITS-1:0]   x;
      logic [POS_BITS-1:0]   y;
      logic [IDX_BITS-1:0]   wr_index;
      logic [TEXEL_BITS-1:0] wr_texel;
   } pos_word_type;

   typedef struct packed {
      logic                  is_write;
      logic [ADDR_BITS-1:0]  addr;
      logic [TEXEL_BITS-1:0] wr_texel;
      logic [POS_BITS-1:0]   x;
      logic [POS_BITS-1:0]   y;
   } fetch_word_type;

   typedef struct packed {
      logic [POS_BITS-1:0]   y;
      logic [POS_BITS-1:0]   x;
      logic [TEXEL_BITS-1:0] texel;
   } result_word_type;

   // size register to effective size: zero acts as one, large values saturate
   function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] s);
      logic [SIZE_BITS-1:0] r;
      if (s == '0) begin
         r = SIZE_BITS'(1);
      end else if (s > SIZE_BITS'(MAX_SIZE)) begin
         r = SIZE_BITS'(MAX_SIZE);
      end else begin
         r = s;
      end
      return r;
   endfunction

   // fold a signed coordinate into [0, one]
   function automatic logic [FX_BITS-1:0] wrap_coord(input logic [COORD_BITS-1:0] pat,
                                                     input logic [1:0] mode);
      logic [FRAC_BITS-1:0] frac;
      logic [FX_BITS-1:0]   r;
      frac = pat[FRAC_BITS-1:0];
      case (mode)
         WRAP_CLAMP: begin
            if (pat[COORD_BITS-1]) begin
               r = '0;
            end else if (pat > ONE_WIDE) begin
               r = ONE_FX;
            end else begin
               r = pat[FX_BITS-1:0];
            end
         end
         WRAP_MIRROR: begin
            if (pat[FRAC_BITS]) begin
               r = ONE_FX - {1'b0, frac};
            end else begin
               r = {1'b0, frac};
            end
         end
         default: r = {1'b0, frac};
      endcase
      return r;
   endfunction

   // scale by size-1, round half up, clamp to the last texel
   function automatic logic [POS_BITS-1:0] to_texel(input logic [FX_BITS-1:0] c,
                                                    input logic [POS_BITS-1:0] lim);
      logic [FX_BITS+POS_BITS-1:0] prod;
      logic [FX_BITS+POS_BITS:0]   sum;
      logic [POS_BITS:0]           p;
      prod = (FX_BITS + POS_BITS)'(c) * (FX_BITS + POS_BITS)'(lim);
      sum  = {1'b0, prod} + (FX_BITS + POS_BITS + 1)'(HALF_FX);
      p    = sum[FRAC_BITS+POS_BITS:FRAC_BITS];
      return (p > {1'b0, lim}) ? lim : p[POS_BITS-1:0];
   endfunction

endpackage

// File: src/twns_wrap.sv
// first pipeline stage: per-axis wrap of u and v, vertical flip of v
// depends on twns_pkg

module twns_wrap (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic                            in_action,
   input  logic [twns_pkg::COORD_BITS-1:0] in_u,
   input  logic [twns_pkg::COORD_BITS-1:0] in_v,
   input  logic [twns_pkg::IDX_BITS-1:0]   in_wr_index,
   input  logic [twns_pkg::TEXEL_BITS-1:0] in_wr_texel,
   input  twns_pkg::cfg_type               cfg,
   output logic                            out_valid,
   output twns_pkg::coord_word_type        out_word
);
   import twns_pkg::*;

   logic           valid_ff;
   coord_word_type word_ff;
   coord_word_type word_in;

   always_comb begin
      word_in.is_write = (in_action == ACT_WRITE);
      word_in.u        = wrap_coord(in_u, cfg.wrap_u);
      word_in.vf       = ONE_FX - wrap_coord(in_v, cfg.wrap_v);
      word_in.wr_index = in_wr_index;
      word_in.wr_texel = in_wr_texel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// File: src/twns_scale.sv
// second pipeline stage: scale wrapped coordinates to texel column and row
// depends on twns_pkg

module twns_scale (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  twns_pkg::coord_word_type in_word,
   input  twns_pkg::cfg_type        cfg,
   output logic                     out_valid,
   output twns_pkg::pos_word_type   out_word
);
   import twns_pkg::*;

   logic         valid_ff;
   pos_word_type word_ff;
   pos_word_type word_in;

   always_comb begin
      word_in.is_write = in_word.is_write;
      word_in.x        = to_texel(in_word.u, cfg.lim_x);
      word_in.y        = to_texel(in_word.vf, cfg.lim_y);
      word_in.wr_index = in_word.wr_index;
      word_in.wr_texel = in_word.wr_texel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// File: src/twns_addr.sv
// third pipeline stage: linear texel address y*width+x, or the write index
// depends on twns_pkg

module twns_addr (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  twns_pkg::pos_word_type   in_word,
   input  twns_pkg::cfg_type        cfg,
   output logic                     out_valid,
   output twns_pkg::fetch_word_type out_word
);
   import twns_pkg::*;

   localparam int LIN_BITS = POS_BITS + SIZE_BITS;

   logic           valid_ff;
   fetch_word_type word_ff;
   fetch_word_type word_in;
   logic [LIN_BITS-1:0] lin;

   always_comb begin
      lin = LIN_BITS'(in_word.y) * LIN_BITS'(cfg.width) + LIN_BITS'(in_word.x);
      word_in.is_write = in_word.is_write;
      if (in_word.is_write) begin
         word_in.addr = in_word.wr_index[ADDR_BITS-1:0];
      end else begin
         word_in.addr = lin[ADDR_BITS-1:0];
      end
      word_in.wr_texel = in_word.wr_texel;
      word_in.x        = in_word.x;
      word_in.y        = in_word.y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// File: src/twns_store.sv
// fourth pipeline stage: texel memory, one write or one registered read per cycle
// depends on twns_pkg

module twns_store (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  twns_pkg::fetch_word_type  in_word,
   output logic                      out_valid,
   output twns_pkg::result_word_type out_word
);
   import twns_pkg::*;

   logic [TEXEL_BITS-1:0] mem [TEX_DEPTH];
   logic [TEXEL_BITS-1:0] rdata_ff;
   logic [POS_BITS-1:0]   x_ff;
   logic [POS_BITS-1:0]   y_ff;
   logic                  valid_ff;

   always_ff @(posedge clock) begin
      if (in_valid && in_word.is_write) begin
         mem[in_word.addr] <= in_word.wr_texel;
      end
      rdata_ff <= mem[in_word.addr];
      x_ff     <= in_word.x;
      y_ff     <= in_word.y;
   end

   // only samples carry on to the result side
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid && !in_word.is_write;
      end
   end

   assign out_valid      = valid_ff;
   assign out_word.texel = rdata_ff;
   assign out_word.x     = x_ff;
   assign out_word.y     = y_ff;

endmodule

// File: src/texture_wrap_nearest_sampler.sv
// nearest-texel sampler: wrap, scale, address, texel memory, output queue
// path: an accepted sample runs through wrap, scale, address, store, output queue
// throughput: one word per cycle; req_tready drops only while 8 samples sit
// in the pipeline or the output queue (credit count)
// reset: synchronous active high, clears valids, credits, queue pointers and
// registers to width 256, height 256, repeat; texel memory is not cleared
// depends on twns_pkg and the four stage modules

module texture_wrap_nearest_sampler (
   input  logic         clock,
   input  logic         reset,
   // request side
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,  // u_coord, v_coord, write_index, write_texel
   input  logic         req_tuser,  // action
   // result side
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,  // red, green, blue, alpha, texel_x, texel_y
   // configuration writes
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [8:0]   csr_wr_data
);
   import twns_pkg::*;

   localparam int Q_DEPTH = 8;
   localparam int Q_PTR   = $clog2(Q_DEPTH);
   localparam int Q_CNT   = Q_PTR + 1;

   // configuration registers
   logic [SIZE_BITS-1:0] width_ff;
   logic [SIZE_BITS-1:0] height_ff;
   logic [1:0]           wrap_u_ff;
   logic [1:0]           wrap_v_ff;
   logic [SIZE_BITS-1:0] w_eff;
   logic [SIZE_BITS-1:0] h_eff;
   cfg_type              cfg;

   // stage links
   logic            req_word;
   logic            wrap_valid;
   coord_word_type  wrap_word;
   logic            scale_valid;
   pos_word_type    scale_word;
   logic            addr_valid;
   fetch_word_type  addr_word;
   logic            store_valid;
   result_word_type store_word;

   // output queue and credits
   result_word_type     q_mem [Q_DEPTH];
   logic [Q_PTR-1:0]    wr_ptr_ff;
   logic [Q_PTR-1:0]    rd_ptr_ff;
   logic [Q_CNT-1:0]    q_cnt_ff;
   logic [Q_CNT-1:0]    q_cnt_in;
   logic [Q_CNT-1:0]    used_ff;
   logic [Q_CNT-1:0]    used_in;
   logic                rsp_word;
   logic                take_sample;
   result_word_type     head;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_BITS'(MAX_SIZE);
         height_ff <= SIZE_BITS'(MAX_SIZE);
         wrap_u_ff <= WRAP_REPEAT;
         wrap_v_ff <= WRAP_REPEAT;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_TEX_WIDTH:  width_ff  <= csr_wr_data;
            REG_TEX_HEIGHT: height_ff <= csr_wr_data;
            REG_WRAP_U:     wrap_u_ff <= csr_wr_data[1:0];
            REG_WRAP_V:     wrap_v_ff <= csr_wr_data[1:0];
            default: ;
         endcase
      end
   end

   // effective sizes; the user must keep them stable while words are in flight, not enforced here
   always_comb begin
      w_eff      = eff_size(width_ff);
      h_eff      = eff_size(height_ff);
      cfg.lim_x  = POS_BITS'(w_eff - SIZE_BITS'(1));
      cfg.lim_y  = POS_BITS'(h_eff - SIZE_BITS'(1));
      cfg.width  = w_eff;
      cfg.wrap_u = wrap_u_ff;
      cfg.wrap_v = wrap_v_ff;
   end

   // every sample reserves a queue slot when accepted, so the pipeline never stalls
   assign req_tready  = (used_ff < Q_CNT'(Q_DEPTH));
   assign req_word    = req_tvalid && req_tready;
   assign take_sample = req_word && (req_tuser == ACT_SAMPLE);
   assign rsp_word    = rsp_tvalid && rsp_tready;

   twns_wrap u_wrap (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_word),
      .in_action   (req_tuser),
      .in_u        (req_tdata[23:0]),
      .in_v        (req_tdata[47:24]),
      .in_wr_index (req_tdata[63:48]),
      .in_wr_texel (req_tdata[95:64]),
      .cfg         (cfg),
      .out_valid   (wrap_valid),
      .out_word    (wrap_word)
   );

   twns_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (wrap_valid),
      .in_word   (wrap_word),
      .cfg       (cfg),
      .out_valid (scale_valid),
      .out_word  (scale_word)
   );

   twns_addr u_addr (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scale_valid),
      .in_word   (scale_word),
      .cfg       (cfg),
      .out_valid (addr_valid),
      .out_word  (addr_word)
   );

   twns_store u_store (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (addr_valid),
      .in_word   (addr_word),
      .out_valid (store_valid),
      .out_word  (store_word)
   );

   // credit and queue bookkeeping
   always_comb begin
      used_in  = used_ff;
      q_cnt_in = q_cnt_ff;
      if (take_sample && !rsp_word) begin
         used_in = used_ff + Q_CNT'(1);
      end else if (!take_sample && rsp_word) begin
         used_in = used_ff - Q_CNT'(1);
      end
      if (store_valid && !rsp_word) begin
         q_cnt_in = q_cnt_ff + Q_CNT'(1);
      end else if (!store_valid && rsp_word) begin
         q_cnt_in = q_cnt_ff - Q_CNT'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         q_cnt_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         used_ff  <= used_in;
         q_cnt_ff <= q_cnt_in;
         if (store_valid) begin
            wr_ptr_ff <= wr_ptr_ff + Q_PTR'(1);
         end
         if (rsp_word) begin
            rd_ptr_ff <= rd_ptr_ff + Q_PTR'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_valid) begin
         q_mem[wr_ptr_ff] <= store_word;
      end
   end

   assign head       = q_mem[rd_ptr_ff];
   assign rsp_tvalid = (q_cnt_ff != '0);
   assign rsp_tdata  = {head.y, head.x, head.texel};

`ifndef SYNTHESIS
   // credits never overrun the queue
   a_credit_bound : assert property (@(posedge clock) disable iff (reset)
      used_ff <= Q_CNT'(Q_DEPTH))
      else $error("credit count above queue depth");

   // queued words are always covered by credits
   a_queue_covered : assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= used_ff)
      else $error("queue holds more words than credits");

   // an accepted sample with no result leaving takes one credit
   a_credit_take : assert property (@(posedge clock) disable iff (reset)
      (take_sample && !rsp_word) |=> (used_ff == $past(used_ff) + Q_CNT'(1)))
      else $error("sample accepted without taking a credit");
`endif

endmodule

// File: tb/sv/texture_wrap_nearest_sampler_tb.sv
// self-checking testbench for the nearest-texel sampler: directed and random words
// with a local predictor, random idling on both sides and a long output hold-off
// depends on twns_pkg and texture_wrap_nearest_sampler
`timescale 1ns / 100ps

module texture_wrap_nearest_sampler_tb;
   import twns_pkg::*;

   // timing budget
   localparam int PIPE_LATENCY   = 4;      // distance from req accept to rsp offer
   localparam int TAIL_CYCLES    = 3 * PIPE_LATENCY;
   localparam int WATCHDOG_LIMIT = 5000;   // cycles with no handshake on either side
   localparam int HOLD_CYCLES    = 300;    // long receiver hold-off
   localparam int ERROR_PRINTS   = 30;

   // fixed point helpers
   localparam int              STEP = 1 << FRAC_BITS;
   localparam longint unsigned UNIT = longint'(STEP);
   localparam longint unsigned HALF = UNIT >> 1;

   // wrap code with no meaning of its own, behaves as repeat
   localparam logic [1:0] WRAP_SPARE = 2'd3;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] col;
      logic [7:0] row;
   } texel_sample_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;    // u_coord, v_coord, write_index, write_texel
   logic        req_tuser;    // action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;    // red, green, blue, alpha, texel_x, texel_y
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [8:0]  csr_wr_data;

   texture_wrap_nearest_sampler dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // shadow of the texture store; texel_written keeps samples off unwritten entries
   logic [31:0]   texel_shadow [0:TEX_DEPTH-1];
   bit            texel_written [0:TEX_DEPTH-1];

   // shadow of the registers, raw as written
   logic [8:0]    cfg_width  = 9'd256;
   logic [8:0]    cfg_height = 9'd256;
   logic [1:0]    cfg_wrap_u = WRAP_REPEAT;
   logic [1:0]    cfg_wrap_v = WRAP_REPEAT;

   texel_sample_type pending_samples [$];   // expected result words, oldest first
   int            error_count     = 0;
   bit            idle_on         = 1'b1;   // random gaps on both sides
   int            rsp_hold_cycles = 0;      // request for a long receiver hold-off

   // 2 ns clock
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------

   // size register as the block uses it: zero acts as one, large values saturate
   function automatic int unsigned effective_extent(input logic [8:0] s);
      if (s == 9'd0) return 1;
      if (s > 9'd256) return 256;
      return int'(s);
   endfunction

   // fold one signed coordinate into [0, 1]
   function automatic longint unsigned fold_axis(input logic [23:0] raw,
                                                 input logic [1:0]  mode);
      longint          s;
      longint unsigned frac;
      s    = longint'($signed(raw));
      frac = longint'(raw[FRAC_BITS-1:0]);
      if (mode == WRAP_CLAMP) begin
         if (s < 0) return 0;
         return (longint'(s) > longint'(UNIT)) ? UNIT : longint'(s);
      end
      // mirrored repeat inverts the fraction when the integer part is odd
      if (mode == WRAP_MIRROR && raw[FRAC_BITS]) return UNIT - frac;
      return frac;
   endfunction

   // scale by size-1, halves round up, never past the last texel
   function automatic int unsigned snap_to_grid(input longint unsigned c,
                                                input int unsigned     size);
      longint unsigned lim;
      longint unsigned p;
      lim = longint'(size) - 1;
      p   = (c * lim + HALF) >> FRAC_BITS;
      return int'((p > lim) ? lim : p);
   endfunction

   function automatic void locate_texel(input  logic [23:0] u_raw,
                                        input  logic [23:0] v_raw,
                                        output logic [7:0]  col,
                                        output logic [7:0]  row,
                                        output int unsigned addr);
      int unsigned w;
      int unsigned h;
      int unsigned cx;
      int unsigned cy;
      w    = effective_extent(cfg_width);
      h    = effective_extent(cfg_height);
      cx   = snap_to_grid(fold_axis(u_raw, cfg_wrap_u), w);
      // v is flipped: row 0 sits at v = 1
      cy   = snap_to_grid(UNIT - fold_axis(v_raw, cfg_wrap_v), h);
      col  = cx[7:0];
      row  = cy[7:0];
      addr = (cy * w + cx) % TEX_DEPTH;
   endfunction

   // update the shadow for one accepted request word
   function automatic void absorb_word(input logic act, input logic [95:0] data);
      texel_sample_type s;
      logic [7:0]    col;
      logic [7:0]    row;
      int unsigned   addr;
      logic [31:0]   t;
      if (act == ACT_WRITE) begin
         texel_shadow[data[63:48]]  = data[95:64];
         texel_written[data[63:48]] = 1'b1;
      end else begin
         locate_texel(data[23:0], data[47:24], col, row, addr);
         t       = texel_shadow[addr];
         s.red   = t[7:0];
         s.green = t[15:8];
         s.blue  = t[23:16];
         s.alpha = t[31:24];
         s.col   = col;
         s.row   = row;
         pending_samples.insert(pending_samples.size(), s);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   function automatic logic [95:0] pack_word(input logic [23:0] u, input logic [23:0] v,
                                             input logic [15:0] idx,
                                             input logic [31:0] texel);
      return {texel, idx, v, u};
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // coordinates: full range, near the unit square, on integer borders, inside [0, 1]
   function automatic logic [23:0] rand_coord();
      int k;
      case ($urandom_range(0, 3))
         0: return 24'($urandom);
         1: return 24'(int'($urandom_range(0, 4 * STEP)) - 2 * STEP);
         2: begin
            k = int'($urandom_range(0, 6)) - 3;
            return 24'(k * STEP + int'($urandom_range(0, 4)) - 2);
         end
         default: return 24'($urandom_range(0, STEP));
      endcase
   endfunction

   // sizes with the out-of-range codes mixed in
   function automatic logic [8:0] pick_extent();
      case ($urandom_range(0, 9))
         0: return 9'd1;
         1: return 9'd256;
         2: return 9'd0;
         3: return 9'($urandom_range(257, 511));
         4: return 9'd2;
         default: return 9'($urandom_range(1, 256));
      endcase
   endfunction

   task automatic report_error(input string msg);
      if (error_count < ERROR_PRINTS) $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // offer one word and hold it until accepted; returns at the accepting edge
   task automatic send_word(input logic act, input logic [95:0] data);
      int gap;
      gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= data;
      // handshake is judged at the falling clock edge, when everything is settled
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      absorb_word(act, data);
      @(posedge clock);
   endtask

   // write word; the coordinate fields carry noise
   task automatic store_texel(input logic [15:0] idx, input logic [31:0] texel);
      send_word(ACT_WRITE, pack_word(24'($urandom), 24'($urandom), idx, texel));
   endtask

   // sample word, preceded by a write when the addressed texel is still unwritten
   task automatic sample_point(input logic [23:0] u, input logic [23:0] v);
      logic [7:0]  col;
      logic [7:0]  row;
      int unsigned addr;
      locate_texel(u, v, col, row, addr);
      if (!texel_written[addr]) store_texel(addr[15:0], $urandom);
      send_word(ACT_SAMPLE, pack_word(u, v, 16'($urandom), $urandom));
   endtask

   // stop offering, wait for every expected word, then let writes in flight settle
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // write all four registers on consecutive edges; only called with the block idle
   task automatic set_config(input logic [8:0] w, input logic [8:0] h,
                             input logic [1:0] wu, input logic [1:0] wv);
      logic [1:0] reg_ids [4];
      logic [8:0] vals [4];
      int         i;
      reg_ids = '{REG_TEX_WIDTH, REG_TEX_HEIGHT, REG_WRAP_U, REG_WRAP_V};
      vals    = '{w, h, 9'(wu), 9'(wv)};
      for (i = 0; i < 4; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= reg_ids[i];
         csr_wr_data <= vals[i];
         @(posedge clock);
      end
      csr_wr_en  <= 1'b0;
      cfg_width  = w;
      cfg_height = h;
      cfg_wrap_u = wu;
      cfg_wrap_v = wv;
      // let the block pick up the new setting before the next word
      repeat (2) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // reset setting: 256 x 256, repeat on both axes; corner texels and extreme coords
   task automatic test_reset_defaults();
      store_texel(16'hFFFF, 32'hFFFF_FFFF);
      store_texel(16'h0000, 32'h0000_0000);
      sample_point(24'h00FFFF, 24'h000000);   // last column, last row
      sample_point(24'h000000, 24'h00FFFF);   // first column, first row
      sample_point(24'h7FFFFF, 24'h800000);
      sample_point(24'h800000, 24'h7FFFFF);
      sample_point(24'hFFFFFF, 24'hFFFFFF);
   endtask

   // each wrap mode, the spare code, zero and oversize sizes, half-way rounding
   task automatic test_wrap_modes();
      drain_pipeline();
      set_config(9'd3, 9'd5, WRAP_CLAMP, WRAP_MIRROR);
      sample_point(24'h800000, 24'h018000);   // negative clamps to 0; odd floor mirrors
      sample_point(24'h020000, 24'hFF8000);   // above one clamps; negative mirror
      sample_point(24'h010000, 24'h004000);   // exactly one
      sample_point(24'h004000, 24'h000000);   // 0.25 * 2 lands on a half, rounds up
      drain_pipeline();
      set_config(9'd0, 9'd511, WRAP_MIRROR, WRAP_SPARE);
      sample_point(24'h01C000, 24'h7FFFFF);
      sample_point(24'hFE4000, 24'h123456);
      drain_pipeline();
      set_config(9'd1, 9'd1, WRAP_REPEAT, WRAP_CLAMP);
      sample_point(24'h345678, 24'hFFFFFF);
      sample_point(24'h000000, 24'h7FFFFF);
      drain_pipeline();
      set_config(9'd256, 9'd2, WRAP_SPARE, WRAP_CLAMP);
      sample_point(24'h00FFFF, 24'h008000);
      sample_point(24'hFF0001, 24'h007FFF);
   endtask

   // receiver holds off for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      int n;
      drain_pipeline();
      set_config(9'd4, 9'd4, WRAP_REPEAT, WRAP_MIRROR);
      idle_on         = 1'b0;
      rsp_hold_cycles = HOLD_CYCLES;
      for (n = 0; n < 48; n++) sample_point(rand_coord(), rand_coord());
      idle_on = 1'b1;
   endtask

   // random phases, each with a fresh setting; every third phase runs without gaps
   task automatic test_random_traffic();
      int phase;
      int n;
      for (phase = 0; phase < 8; phase++) begin
         drain_pipeline();
         set_config(pick_extent(), pick_extent(),
                    2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
         idle_on = (phase % 3) != 2;
         for (n = 0; n < 140; n++) begin
            if ($urandom_range(0, 4) == 0) store_texel(16'($urandom), $urandom);
            else sample_point(rand_coord(), rand_coord());
         end
      end
      idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------------

   task automatic compare_field(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want) report_error($sformatf("%s got %h want %h", name, got, want));
   endtask

   task automatic check_sample(input logic [47:0] word);
      texel_sample_type want;
      if (pending_samples.size() == 0) begin
         report_error($sformatf("result word %h with nothing expected", word));
         return;
      end
      want = pending_samples.pop_front();
      compare_field("red",     word[7:0],   want.red);
      compare_field("green",   word[15:8],  want.green);
      compare_field("blue",    word[23:16], want.blue);
      compare_field("alpha",   word[31:24], want.alpha);
      compare_field("texel_x", word[39:32], want.col);
      compare_field("texel_y", word[47:40], want.row);
   endtask

   // a result word is taken at the next rising edge; check it while it is settled
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_sample(rsp_tdata);
   end

   // ---------------------------------------------------------------------------
   // receiver: random ready runs and stalls, plus the long hold-off on request
   // ---------------------------------------------------------------------------
   initial begin : receiver
      int   run_left;
      logic run_level;
      run_left   = 0;
      run_level  = 1'b1;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            run_left        = rsp_hold_cycles;
            run_level       = 1'b0;
            rsp_hold_cycles = 0;
         end else if (run_left == 0) begin
            if (!idle_on) begin
               run_level = 1'b1;
               run_left  = 1;
            end else if ($urandom_range(0, 1) == 1) begin
               run_level = 1'b1;
               run_left  = $urandom_range(1, 20);
            end else begin
               run_level = 1'b0;
               run_left  = pick_gap();
            end
         end
         rsp_tready <= run_level;
         run_left--;
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog: ends the run when no word moves on either side for too long
   // ---------------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(negedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = ACT_SAMPLE;
      req_tdata   = '0;
      csr_wr_en   = 1'b0;
      csr_index   = REG_TEX_WIDTH;
      csr_wr_data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_wrap_modes();
      test_backpressure();
      test_random_traffic();
      drain_pipeline();

      if (pending_samples.size() != 0)
         report_error($sformatf("%0d result words never arrived", pending_samples.size()));
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
